// ----- src/pfd_pkg.sv -----
package pfd_pkg;

    localparam logic [7:0] HDR1_BYTE = 8'h55;
    localparam logic [7:0] HDR2_BYTE = 8'hAA;
    localparam logic [7:0] LEN_BYTE  = 8'h14;
    localparam logic [7:0] TRL1_BYTE = 8'h0D;
    localparam logic [7:0] TRL2_BYTE = 8'h0A;

    localparam int unsigned PAYLOAD_LEN = 20;
    localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);

    localparam logic [31:0] SEL_POS_ZERO = 32'h0000_0000;
    localparam logic [31:0] SEL_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] SEL_ONE      = 32'h3F80_0000;

    localparam logic KIND_CURRENT = 1'b0;
    localparam logic KIND_TARGET  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_TRL1    = 3'd4,
        PH_TRL2    = 3'd5,
        PH_IGNORE  = 3'd6
    } t_phase;

    typedef struct packed {
        logic        record_kind;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] heading;
    } t_record;

endpackage

// ----- src/pfd_in_if.sv -----
interface pfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_start;

    modport source (output valid, output rx_byte, output buffer_start, input ready);
    modport sink   (input valid, input rx_byte, input buffer_start, output ready);
endinterface

// ----- src/pfd_out_if.sv -----
interface pfd_out_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] heading;

    modport source (output valid, output record_kind, output pos_x, output pos_y,
                    output pos_z, output heading, input ready);
    modport sink   (input valid, input record_kind, input pos_x, input pos_y,
                    input pos_z, input heading, output ready);
endinterface

// ----- src/pfd_parser.sv -----
module pfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_buffer_start,
    output logic             o_emit,
    output pfd_pkg::t_record o_record
);
    import pfd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [IDX_W-1:0]       r_index, n_index;
    logic [7:0]             r_store [PAYLOAD_LEN];
    t_phase                 cur_phase;
    logic [IDX_W-1:0]       cur_index;
    logic [IDX_W-1:0]       wr_index;
    logic                   store_we;
    logic [31:0]            sel_word;

    assign sel_word = {r_store[3], r_store[2], r_store[1], r_store[0]};

    assign o_record.record_kind = (sel_word == SEL_ONE) ? KIND_TARGET : KIND_CURRENT;
    assign o_record.pos_x   = {r_store[7],  r_store[6],  r_store[5],  r_store[4]};
    assign o_record.pos_y   = {r_store[11], r_store[10], r_store[9],  r_store[8]};
    assign o_record.pos_z   = {r_store[15], r_store[14], r_store[13], r_store[12]};
    assign o_record.heading = {r_store[19], r_store[18], r_store[17], r_store[16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_index <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && store_we) begin
            r_store[wr_index] <= i_rx_byte;
        end
    end

    always_comb begin
        // A buffer start forces the parser back to hunting before the byte is parsed.
        cur_phase = i_buffer_start ? PH_HUNT1 : r_phase;
        cur_index = i_buffer_start ? '0 : r_index;
        n_phase   = cur_phase;
        n_index   = cur_index;
        wr_index  = (cur_index >= IDX_W'(PAYLOAD_LEN)) ? '0 : cur_index;
        store_we  = 1'b0;
        o_emit    = 1'b0;
        unique case (cur_phase)
            PH_HUNT2: begin
                n_phase = (i_rx_byte == HDR2_BYTE) ? PH_LEN : PH_HUNT1;
            end
            PH_LEN: begin
                if (i_rx_byte == LEN_BYTE) begin
                    n_phase = PH_PAYLOAD;
                    n_index = '0;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_PAYLOAD: begin
                store_we = 1'b1;
                if (wr_index == IDX_W'(PAYLOAD_LEN - 1)) begin
                    n_index = '0;
                    n_phase = PH_TRL1;
                end else begin
                    n_index = wr_index + IDX_W'(1);
                end
            end
            PH_TRL1: begin
                n_phase = (i_rx_byte == TRL1_BYTE) ? PH_TRL2 : PH_HUNT1;
            end
            PH_TRL2: begin
                n_phase = PH_IGNORE;
                o_emit  = (i_rx_byte == TRL2_BYTE) &&
                          (sel_word == SEL_POS_ZERO || sel_word == SEL_NEG_ZERO ||
                           sel_word == SEL_ONE);
            end
            PH_IGNORE: begin
                n_phase = PH_IGNORE;
            end
            default: begin
                // Hunting for the first header byte; the unused code lands here too.
                n_phase = (i_rx_byte == HDR1_BYTE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

endmodule

// ----- src/pose_frame_deframer.sv -----
// Channel  Dir  Payload                                   Handshake
// i_in     in   rx_byte[7:0], buffer_start                valid/ready
// o_out    out  record_kind, pos_x, pos_y, pos_z, heading valid/ready
//
// One byte is accepted per cycle while the input side does not stall. A byte is
// parsed while it sits in the input register, and a finished record is then
// loaded into the output register, from which it is offered.
// Synchronous active-low reset returns the parser to header hunting; the
// payload store is not cleared. The input side stalls only while a record waits
// in the output register and a byte is pending.
module pose_frame_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfd_in_if.sink    i_in,
    pfd_out_if.source o_out
);
    import pfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_valid;
    t_record    r_out;
    logic       advance;
    logic       emit;
    t_record    record;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.rx_byte;
            r_in_start <= i_in.buffer_start;
        end
    end

    pfd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_rx_byte      (r_in_byte),
        .i_buffer_start (r_in_start),
        .o_emit         (emit),
        .o_record       (record)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= record;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.record_kind = r_out.record_kind;
    assign o_out.pos_x       = r_out.pos_x;
    assign o_out.pos_y       = r_out.pos_y;
    assign o_out.pos_z       = r_out.pos_z;
    assign o_out.heading     = r_out.heading;

endmodule

// ----- tb/sv/tb_pose_frame_deframer.sv -----
`timescale 1ns / 1ps

module tb_pose_frame_deframer;
    import pfd_pkg::*;

    // Ways a generated buffer can deviate from a clean frame.
    typedef enum int {
        FLAW_NONE,
        FLAW_HDR1,
        FLAW_HDR2,
        FLAW_LEN,
        FLAW_TRL1,
        FLAW_TRL2,
        FLAW_CUT,
        FLAW_DUP_HDR
    } t_flaw;

    class pose_scoreboard;
        t_phase           phase;
        logic [IDX_W-1:0] idx;
        logic [7:0]       store [PAYLOAD_LEN];
        t_record          due_q [$];
        int               errors;
        int               records_due;

        function new();
            phase = PH_HUNT1;
            idx = '0;
            foreach (store[i]) store[i] = '0;
            errors = 0;
            records_due = 0;
        endfunction

        function logic [31:0] word(int w);
            int b = (w * 4) % PAYLOAD_LEN;
            return {store[b + 3], store[b + 2], store[b + 1], store[b]};
        endfunction

        // Advances the parser by one accepted byte and queues any record it finishes.
        function void note_byte(logic [7:0] b, logic start);
            logic [31:0] sel;
            t_record     rec;
            if (start) begin
                phase = PH_HUNT1;
                idx = '0;
            end
            case (phase)
                PH_HUNT2: phase = (b == HDR2_BYTE) ? PH_LEN : PH_HUNT1;
                PH_LEN: begin
                    if (b == LEN_BYTE) begin
                        phase = PH_PAYLOAD;
                        idx = '0;
                    end else begin
                        phase = PH_HUNT1;
                    end
                end
                PH_PAYLOAD: begin
                    store[idx] = b;
                    if (idx == PAYLOAD_LEN - 1) begin
                        idx = '0;
                        phase = PH_TRL1;
                    end else begin
                        idx = idx + 1'b1;
                    end
                end
                PH_TRL1: phase = (b == TRL1_BYTE) ? PH_TRL2 : PH_HUNT1;
                PH_TRL2: begin
                    if (b == TRL2_BYTE) begin
                        sel = word(0);
                        if (sel == SEL_POS_ZERO || sel == SEL_NEG_ZERO || sel == SEL_ONE) begin
                            rec.record_kind = (sel == SEL_ONE) ? KIND_TARGET : KIND_CURRENT;
                            rec.pos_x = word(1);
                            rec.pos_y = word(2);
                            rec.pos_z = word(3);
                            rec.heading = word(4);
                            due_q.push_back(rec);
                            records_due++;
                        end
                    end
                    phase = PH_IGNORE;
                end
                PH_IGNORE: ;
                default: phase = (b == HDR1_BYTE) ? PH_HUNT2 : PH_HUNT1;
            endcase
        endfunction

        function void check_record(t_record got);
            t_record want;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected record: kind=%0d x=%h y=%h z=%h hd=%h",
                             got.record_kind, got.pos_x, got.pos_y, got.pos_z, got.heading);
                return;
            end
            want = due_q.pop_front();
            if (got.record_kind !== want.record_kind || got.pos_x !== want.pos_x ||
                got.pos_y !== want.pos_y || got.pos_z !== want.pos_z ||
                got.heading !== want.heading) begin
                errors++;
                if (errors <= 10)
                    $display("record mismatch: want kind=%0d x=%h y=%h z=%h hd=%h",
                             want.record_kind, want.pos_x, want.pos_y, want.pos_z,
                             want.heading, "\n                  got  kind=%0d x=%h y=%h z=%h hd=%h",
                             got.record_kind, got.pos_x, got.pos_y, got.pos_z, got.heading);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_GOAL      = 1750;
    localparam int RECORD_GOAL    = 40;
    localparam int QUIET_FROM     = 1500;

    logic i_clk;
    logic i_rst_n;

    pfd_in_if  in_if ();
    pfd_out_if out_if ();

    pose_frame_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    pose_scoreboard sb = new();

    bit idle_en = 1'b0;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] other_than(input logic [7:0] v);
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (r == v);
        return r;
    endfunction

    function automatic void push_word(ref logic [7:0] q[$], input logic [31:0] w);
        for (int k = 0; k < 4; k++) q.push_back(w[8 * k +: 8]);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly the three accepted selectors; the rest are near misses or noise.
    function automatic logic [31:0] pick_selector();
        int r = $urandom_range(0, 9);
        if (r < 3) return SEL_POS_ZERO;
        if (r < 6) return SEL_NEG_ZERO;
        if (r < 9) return SEL_ONE;
        if ($urandom_range(0, 1) == 0) return $urandom;
        return SEL_ONE ^ (32'h1 << $urandom_range(0, 31));
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic s);
        if (idle_en && $urandom_range(0, 11) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.rx_byte <= b;
        in_if.buffer_start <= s;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(b, s);
        @(negedge i_clk);
    endtask

    task automatic send_buffer(input logic [31:0] sel, px, py, pz, hd, input t_flaw flaw,
                               input bit lead_start, input int noise_len, input int tail_len);
        logic [7:0] q [$];
        logic [7:0] n;
        int         keep;
        repeat (noise_len) begin
            n = 8'($urandom_range(0, 255));
            q.push_back((n == HDR1_BYTE) ? 8'h00 : n);
        end
        if (flaw == FLAW_DUP_HDR) q.push_back(HDR1_BYTE);
        q.push_back((flaw == FLAW_HDR1) ? other_than(HDR1_BYTE) : HDR1_BYTE);
        q.push_back((flaw == FLAW_HDR2) ? other_than(HDR2_BYTE) : HDR2_BYTE);
        q.push_back((flaw == FLAW_LEN) ? other_than(LEN_BYTE) : LEN_BYTE);
        push_word(q, sel);
        push_word(q, px);
        push_word(q, py);
        push_word(q, pz);
        push_word(q, hd);
        q.push_back((flaw == FLAW_TRL1) ? other_than(TRL1_BYTE) : TRL1_BYTE);
        q.push_back((flaw == FLAW_TRL2) ? other_than(TRL2_BYTE) : TRL2_BYTE);
        if (flaw == FLAW_CUT) begin
            keep = $urandom_range(1, q.size() - 1);
            while (q.size() > keep) void'(q.pop_back());
        end
        // Trailing bytes land after the frame; once the second trailer position is reached, the parser ignores them.
        repeat (tail_len) q.push_back(8'($urandom_range(0, 255)));
        items_sent += q.size();
        foreach (q[i]) put_byte(q[i], lead_start && i == 0);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : record_monitor
        t_record got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.record_kind = out_if.record_kind;
            got.pos_x = out_if.pos_x;
            got.pos_y = out_if.pos_y;
            got.pos_z = out_if.pos_z;
            got.heading = out_if.heading;
            sb.check_record(got);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int    n_buf;
        int    r;
        t_flaw flaw;
        n_buf = 0;
        in_if.valid = 1'b0;
        in_if.rx_byte = 8'h00;
        in_if.buffer_start = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_en = 1'b1;

        // A target frame before any buffer start, carrying extreme words, then ignored bytes.
        send_buffer(SEL_ONE, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h8000_0000,
                    FLAW_NONE, 1'b0, 0, 4);
        wait_drained();

        while (items_sent < ITEM_GOAL || sb.records_due < RECORD_GOAL) begin
            idle_en = (items_sent < QUIET_FROM);
            if (n_buf == 15) wait_drained();
            if (n_buf == 30) begin
                // Back-to-back clean frames while the receiver holds off.
                idle_en = 1'b0;
                hold_req = 1'b1;
                repeat (6)
                    send_buffer(pick_selector(), pick_word(), pick_word(), pick_word(),
                                pick_word(), FLAW_NONE, 1'b1, 0, 0);
            end else begin
                r = $urandom_range(0, 19);
                flaw = (r < 13) ? FLAW_NONE : t_flaw'(r - 12);
                send_buffer(pick_selector(), pick_word(), pick_word(), pick_word(),
                            pick_word(), flaw, $urandom_range(0, 19) != 0,
                            ($urandom_range(0, 9) < 3) ? $urandom_range(1, 6) : 0,
                            $urandom_range(0, 4));
            end
            n_buf++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
